@@ rtl/gbn_pkg.sv @@
// Shared types, constants and helpers for the go-back-n sender window unit.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package gbn_pkg;

    localparam int WINDOW       = 16;
    localparam int PACKET_BYTES = 1024;
    localparam int MAX_PACKETS  = 65535;

    localparam int IDX_W   = 16;                    // packet number width
    localparam int SEQ_W   = 26;                    // byte sequence number width
    localparam int TICK_W  = 32;
    localparam int SLOT_W  = $clog2(WINDOW);        // stamp slot index width
    localparam int WCNT_W  = $clog2(WINDOW + 1);    // effective window width
    localparam int CFG_W   = 32;                    // widest register
    localparam int CFGI_W  = 2;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_ACK   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_RESEND = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_TOTAL   = 2'd2;

    localparam logic [6:0]        WINDOW_RST  = 7'd4;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd500;
    localparam logic [IDX_W-1:0]  TOTAL_RST   = 16'd1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] ack_index;
    } gbn_in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] send_index;
        logic [SEQ_W-1:0] seq_number;
        logic             final_packet;
        logic             end_of_run;
    } gbn_out_t;

    // controller -> datapath
    typedef struct packed {
        logic start;        // reopen the transfer at packet 0
        logic slide;        // move base past the accepted ack
        logic mark_final;   // final ack seen: set finished, hold ack
        logic tick;         // advance the time counter
        logic retx_begin;   // point the cursor at the window base
        logic emit_fill;    // send the next unsent packet
        logic emit_retx;    // resend the packet under the cursor
        logic emit_final;   // report transfer complete
    } gbn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
        logic ack_ok;       // ack inside the sent range of a live transfer
        logic ack_final;    // ack names the final packet
        logic fill_more;    // window and transfer allow another new packet
        logic fill_last;    // the packet being sent now is the last new one
        logic timeout;      // oldest outstanding packet has expired
        logic retx_last;    // cursor sits on the newest sent packet
    } gbn_sts_t;

    function automatic logic [SEQ_W-1:0] seq_of(input logic [IDX_W-1:0] idx);
        logic [TICK_W-1:0] prod;
        prod = TICK_W'(idx) * TICK_W'(PACKET_BYTES);
        return prod[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/go_back_n_sender_window_unit.sv @@
// Top level of the go-back-n sender window unit: joins controller and datapath.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
//
// in channel (in_valid/in_stall/in_data): one word is a request - start a
//   transfer, one time tick, or a cumulative ack with its packet number.
// out channel (out_valid/out_stall/out_data): one word per packet to send or
//   resend, or one transfer-complete word; a request's last word has end_of_run.
// cfg port (cfg_we/cfg_index/cfg_data): window, timeout in ticks and transfer
//   length; write only while the unit is idle.
// Timing: a request is taken in the idle state. A start or a sliding ack moves
//   to the fill state, which loads one send per cycle into the output register
//   while the output is not stalled; a slide with nothing new returns to idle.
//   A tick passes through the check state for the timeout test and, on a
//   timeout, the resend state, loading one resend per unstalled cycle. A final
//   ack loads the completion word in the done state; an ignored word is dropped.
// Stall: a stalled output word holds and the run waits with it; in_stall stays
//   high until the run's last word is loaded.
// Reset: window 4, timeout 500, length 1, base, next and tick count at zero; the
//   unit is idle and ready the cycle after rst_n rises.
`default_nettype none

module go_back_n_sender_window_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire gbn_pkg::gbn_in_t           in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output gbn_pkg::gbn_out_t               out_data,
    input  wire logic                       cfg_we,
    input  wire logic [gbn_pkg::CFGI_W-1:0] cfg_index,
    input  wire logic [gbn_pkg::CFG_W-1:0]  cfg_data
);

    gbn_pkg::gbn_cmd_t cmd;
    gbn_pkg::gbn_sts_t sts;

    // sequencer: owns the input handshake and paces each run
    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // window state, stamps and the output word register
    gbn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ack_index (in_data.ack_index),
        .cmd       (cmd),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/gbn_ctrl.sv @@
// Sequencer for the go-back-n sender: decodes accepted words and steps
// through send, resend and completion runs. Uses gbn_pkg.
`default_nettype none

module gbn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        req_type,
    input  wire gbn_pkg::gbn_sts_t sts,
    output logic                   in_stall,
    output gbn_pkg::gbn_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_RETX  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == gbn_pkg::REQ_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_FILL;
                    end
                    else if (req_type == gbn_pkg::REQ_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = ST_CHECK;
                    end
                    else if (req_type == gbn_pkg::REQ_ACK && sts.ack_ok)
                    begin
                        if (sts.ack_final)
                        begin
                            cmd.mark_final = 1'b1;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            cmd.slide  = 1'b1;
                            state_next = ST_FILL;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                if (!sts.fill_more)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                begin
                    cmd.emit_fill = 1'b1;
                    if (sts.fill_last)
                        state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (sts.timeout)
                begin
                    cmd.retx_begin = 1'b1;
                    state_next     = ST_RETX;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_RETX:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_retx = 1'b1;
                    if (sts.retx_last)
                        state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ rtl/gbn_dp.sv @@
// Datapath of the go-back-n sender: config registers, window pointers,
// tick counter, per-slot send stamps and the output word register. Uses gbn_pkg.
`default_nettype none

module gbn_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gbn_pkg::CFGI_W-1:0]  cfg_index,
    input  wire logic [gbn_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic [gbn_pkg::IDX_W-1:0]   ack_index,
    input  wire gbn_pkg::gbn_cmd_t           cmd,
    input  wire logic                        out_stall,
    output gbn_pkg::gbn_sts_t                sts,
    output logic                             out_valid,
    output gbn_pkg::gbn_out_t                out_data
);

    localparam int IW = gbn_pkg::IDX_W;
    localparam int TW = gbn_pkg::TICK_W;
    localparam int SW = gbn_pkg::SLOT_W;
    localparam int WW = gbn_pkg::WCNT_W;

    logic [6:0]    win_reg;
    logic [TW-1:0] tmo_reg;
    logic [IW-1:0] tot_reg;

    logic [IW-1:0] base_reg, base_next;
    logic [IW-1:0] nxt_reg,  nxt_next;
    logic [IW-1:0] cur_reg,  cur_next;
    logic [TW-1:0] tick_reg, tick_next;
    logic          fin_reg,  fin_next;
    logic [TW-1:0] stamp_reg [gbn_pkg::WINDOW];

    logic              out_valid_reg, out_valid_next;
    gbn_pkg::gbn_out_t out_data_reg,  out_data_next;

    logic [WW-1:0] eff_win;
    logic [IW-1:0] eff_tot;
    logic [IW-1:0] last_idx;
    logic [IW:0]   limit;
    logic [IW:0]   nxt_inc;
    logic [IW:0]   cur_inc;
    logic [TW-1:0] age;
    logic          stamp_we;
    logic [SW-1:0] stamp_slot;
    logic [IW-1:0] emit_idx;

    // clamp the configured window and transfer length to their legal ranges
    always_comb
    begin
        if (win_reg == 7'd0)
            eff_win = WW'(1);
        else if (win_reg > 7'(gbn_pkg::WINDOW))
            eff_win = WW'(gbn_pkg::WINDOW);
        else
            eff_win = win_reg[WW-1:0];

        if (tot_reg == '0)
            eff_tot = IW'(1);
        else if (tot_reg > IW'(gbn_pkg::MAX_PACKETS))
            eff_tot = IW'(gbn_pkg::MAX_PACKETS);
        else
            eff_tot = tot_reg;
    end

    assign last_idx = eff_tot - IW'(1);
    assign limit    = {1'b0, base_reg} + (IW+1)'(eff_win);
    assign nxt_inc  = {1'b0, nxt_reg} + (IW+1)'(1);
    assign cur_inc  = {1'b0, cur_reg} + (IW+1)'(1);
    assign age      = tick_reg - stamp_reg[base_reg[SW-1:0]];

    always_comb
    begin
        sts.out_free  = !out_valid_reg || !out_stall;
        sts.ack_ok    = !fin_reg && (ack_index >= base_reg) && (ack_index < nxt_reg);
        sts.ack_final = (ack_index == last_idx);
        sts.fill_more = ({1'b0, nxt_reg} < limit) && (nxt_reg < eff_tot);
        sts.fill_last = !((nxt_inc < limit) && (nxt_inc < {1'b0, eff_tot}));
        sts.timeout   = !fin_reg && (nxt_reg > base_reg) && (age > tmo_reg);
        sts.retx_last = (cur_inc == {1'b0, nxt_reg});
    end

    always_comb
    begin
        base_next      = base_reg;
        nxt_next       = nxt_reg;
        cur_next       = cur_reg;
        tick_next      = tick_reg;
        fin_next       = fin_reg;
        stamp_we       = 1'b0;
        stamp_slot     = nxt_reg[SW-1:0];
        emit_idx       = nxt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cmd.start)
        begin
            base_next = '0;
            nxt_next  = '0;
            fin_next  = 1'b0;
        end
        if (cmd.slide)
            base_next = ack_index + IW'(1);
        if (cmd.mark_final)
        begin
            fin_next = 1'b1;
            cur_next = ack_index;
        end
        if (cmd.tick)
            tick_next = tick_reg + TW'(1);
        if (cmd.retx_begin)
            cur_next = base_reg;

        if (cmd.emit_fill)
        begin
            stamp_we  = 1'b1;
            nxt_next  = nxt_inc[IW-1:0];
            emit_idx  = nxt_reg;
            out_data_next.kind       = gbn_pkg::KIND_SEND;
            out_data_next.end_of_run = sts.fill_last;
        end
        else if (cmd.emit_retx)
        begin
            stamp_we   = 1'b1;
            stamp_slot = cur_reg[SW-1:0];
            cur_next   = cur_inc[IW-1:0];
            emit_idx   = cur_reg;
            out_data_next.kind       = gbn_pkg::KIND_RESEND;
            out_data_next.end_of_run = sts.retx_last;
        end
        else if (cmd.emit_final)
        begin
            emit_idx = cur_reg;
            out_data_next.kind       = gbn_pkg::KIND_DONE;
            out_data_next.end_of_run = 1'b1;
        end

        if (cmd.emit_fill || cmd.emit_retx || cmd.emit_final)
        begin
            out_valid_next              = 1'b1;
            out_data_next.send_index    = emit_idx;
            out_data_next.seq_number    = gbn_pkg::seq_of(emit_idx);
            out_data_next.final_packet  = (emit_idx == last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= gbn_pkg::WINDOW_RST;
            tmo_reg       <= gbn_pkg::TIMEOUT_RST;
            tot_reg       <= gbn_pkg::TOTAL_RST;
            base_reg      <= '0;
            nxt_reg       <= '0;
            tick_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gbn_pkg::CFG_WINDOW:  win_reg <= cfg_data[6:0];
                    gbn_pkg::CFG_TIMEOUT: tmo_reg <= cfg_data[TW-1:0];
                    gbn_pkg::CFG_TOTAL:   tot_reg <= cfg_data[IW-1:0];
                    default:              ;
                endcase
            end
            base_reg      <= base_next;
            nxt_reg       <= nxt_next;
            tick_reg      <= tick_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        if (stamp_we)
            stamp_reg[stamp_slot] <= tick_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/gbn_chk.sv @@
// Port-level checks for the go-back-n sender window unit, bound to the top.
// Depends on gbn_pkg and go_back_n_sender_window_unit.
`default_nettype none

module gbn_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire gbn_pkg::gbn_out_t out_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");

    // completion word closes its run and names the final packet
    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == gbn_pkg::KIND_DONE |->
            out_data.end_of_run && out_data.final_packet)
        else $error("completion word malformed");

    // no word is taken while a run is only partly in the output register
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid || out_data.end_of_run)
        else $error("input taken in the middle of a run");

    // a word leaving mid-run is replaced by the next word of the same run
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.end_of_run |=> out_valid)
        else $error("run ended without end_of_run");

endmodule

bind go_back_n_sender_window_unit gbn_chk u_gbn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

@@ test/gbn_window_checker.sv @@
// Checker for the go-back-n sender window unit: follows the request, result and
// register ports, predicts every result word and compares them in arrival order.
// Depends on gbn_pkg only.
module gbn_window_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  gbn_pkg::gbn_in_t           in_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  gbn_pkg::gbn_out_t          out_data,
    input  logic                       cfg_we,
    input  logic [gbn_pkg::CFGI_W-1:0] cfg_index,
    input  logic [gbn_pkg::CFG_W-1:0]  cfg_data,
    output int                         errors,
    output int                         waiting
);
    import gbn_pkg::*;

    logic [6:0]        reg_window  = WINDOW_RST;
    logic [TICK_W-1:0] reg_timeout = TIMEOUT_RST;
    logic [IDX_W-1:0]  reg_total   = TOTAL_RST;

    int unsigned       win_base  = 0;
    int unsigned       win_next  = 0;
    logic [TICK_W-1:0] tick_now  = '0;
    logic [TICK_W-1:0] sent_at [WINDOW];
    logic              xfer_done = 1'b0;

    gbn_out_t          burst [64];
    int                burst_len;
    gbn_out_t          awaited [$];
    gbn_out_t          want;
    int                slot_i;
    int                mismatches = 0;
    int                backlog    = 0;

    assign errors  = mismatches;
    assign waiting = backlog;

    function automatic int unsigned live_window();
        if (reg_window == 0)
            return 1;
        if (reg_window > WINDOW)
            return WINDOW;
        return reg_window;
    endfunction

    function automatic int unsigned live_total();
        if (reg_total == 0)
            return 1;
        return (reg_total > MAX_PACKETS) ? MAX_PACKETS : reg_total;
    endfunction

    task automatic add_word(input logic [1:0] kind, input int unsigned idx);
        logic [31:0] idx_bits;
        logic [31:0] bytes;
        gbn_out_t    word;
        idx_bits          = idx;
        bytes             = idx * PACKET_BYTES;
        word.kind         = kind;
        word.send_index   = idx_bits[IDX_W-1:0];
        word.seq_number   = bytes[SEQ_W-1:0];
        word.final_packet = (idx == live_total() - 1);
        word.end_of_run   = 1'b0;
        burst[burst_len]  = word;
        burst_len++;
    endtask

    // Send new packets while both the window and the transfer allow.
    task automatic fill_window();
        int unsigned limit;
        limit = win_base + live_window();
        while (win_next < limit && win_next < live_total() && burst_len < 64)
        begin
            sent_at[win_next % WINDOW] = tick_now;
            add_word(KIND_SEND, win_next);
            win_next++;
        end
    endtask

    task automatic model_request(input gbn_in_t req);
        logic [TICK_W-1:0] age;
        int unsigned       idx;
        burst_len = 0;
        case (req.req_type)
            REQ_START:
            begin
                win_base  = 0;
                win_next  = 0;
                xfer_done = 1'b0;
                fill_window();
            end
            REQ_TICK:
            begin
                tick_now = tick_now + 1;
                if (!xfer_done && win_next > win_base)
                begin
                    age = tick_now - sent_at[win_base % WINDOW];
                    if (age > reg_timeout)
                    begin
                        for (idx = win_base; idx < win_next && burst_len < 64; idx++)
                        begin
                            sent_at[idx % WINDOW] = tick_now;
                            add_word(KIND_RESEND, idx);
                        end
                    end
                end
            end
            REQ_ACK:
            begin
                if (!xfer_done && req.ack_index >= win_base && req.ack_index < win_next)
                begin
                    if (req.ack_index == live_total() - 1)
                    begin
                        xfer_done = 1'b1;
                        add_word(KIND_DONE, req.ack_index);
                    end
                    else
                    begin
                        win_base = req.ack_index + 1;
                        fill_window();
                    end
                end
            end
            default: ;
        endcase
        if (burst_len > 0)
            burst[burst_len - 1].end_of_run = 1'b1;
        for (idx = 0; idx < burst_len; idx++)
            awaited = {awaited, burst[idx]};
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_window  = WINDOW_RST;
            reg_timeout = TIMEOUT_RST;
            reg_total   = TOTAL_RST;
            win_base    = 0;
            win_next    = 0;
            tick_now    = '0;
            xfer_done   = 1'b0;
            for (slot_i = 0; slot_i < WINDOW; slot_i++)
                sent_at[slot_i] = '0;
            awaited.delete();
            backlog = 0;
        end
        else
        begin
            // results first: a word leaving now never stems from a request taken now
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: word kind %0d index %0d arrived, none expected",
                             $time, out_data.kind, out_data.send_index);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("kind", want.kind, out_data.kind);
                    check_field("send_index", want.send_index, out_data.send_index);
                    check_field("seq_number", want.seq_number, out_data.seq_number);
                    check_field("final_packet", want.final_packet, out_data.final_packet);
                    check_field("end_of_run", want.end_of_run, out_data.end_of_run);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW:  reg_window  = cfg_data[6:0];
                    CFG_TIMEOUT: reg_timeout = cfg_data[TICK_W-1:0];
                    CFG_TOTAL:   reg_total   = cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                model_request(in_data);
            backlog = awaited.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the go-back-n sender window unit test: makes requests, register writes
// and output stalls, and gives the verdict; gbn_window_checker does the checking.
// Depends on gbn_pkg, go_back_n_sender_window_unit and gbn_window_checker.
module testbench;
    import gbn_pkg::*;

    localparam logic [1:0] REQ_BOGUS   = 2'd3;    // unknown request, dropped by the unit
    localparam int        RUN_LIMIT     = 400000; // watchdog, many times the slowest run
    localparam int        SETTLE_CYCLES = 24;     // covers a tick that resends nothing
    localparam int        HOLD_CYCLES   = 400;    // long receiver hold-off

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    gbn_in_t  in_data   = '0;
    logic     out_stall = 1'b0;
    logic     cfg_we    = 1'b0;
    logic [CFGI_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic     in_stall;
    logic     out_valid;
    gbn_out_t out_data;

    int errors;
    int waiting;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_asks    = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    // Stimulus-side view of the window, kept only to aim acks into the sent range.
    int unsigned fly_base   = 0;
    int unsigned fly_next   = 0;
    int unsigned use_window = 4;
    int unsigned use_total  = 1;
    bit          fly_done   = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    go_back_n_sender_window_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gbn_window_checker window_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .waiting   (waiting)
    );

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: a requested hold-off keeps stall high for a long count of its own,
    // otherwise stall at random with the current percentage.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            out_stall   <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Advance the window view the way an accepted request moves the unit; returns
    // whether the request does any work (ignored requests do not count).
    function automatic bit track_request(input gbn_in_t w);
        int unsigned reach;
        case (w.req_type)
            REQ_START:
            begin
                fly_base = 0;
                fly_done = 1'b0;
                fly_next = (use_window < use_total) ? use_window : use_total;
                return 1'b1;
            end
            REQ_TICK:
                return 1'b1;
            REQ_ACK:
            begin
                if (fly_done || w.ack_index < fly_base || w.ack_index >= fly_next)
                    return 1'b0;
                if (w.ack_index == use_total - 1)
                begin
                    fly_done = 1'b1;
                end
                else
                begin
                    fly_base = w.ack_index + 1;
                    reach    = fly_base + use_window;
                    if (reach > use_total)
                        reach = use_total;
                    if (reach > fly_next)
                        fly_next = reach;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Offer one word and return at the edge that takes it. Stall is sampled at the
    // falling edge, where it already holds its value for the next rising edge.
    task automatic offer(input gbn_in_t w);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] req, input logic [IDX_W-1:0] ack);
        gbn_in_t w;
        w.req_type  = req;
        w.ack_index = ack;
        void'(track_request(w));
        offer(w);
    endtask

    // Mostly well-formed traffic: acks inside the sent range, often the newest
    // packet so transfers run to their end, ticks to age the window, a few
    // restarts; the rest is stray acks and unknown requests.
    task automatic random_request();
        logic [1:0]       req;
        logic [IDX_W-1:0] ack;
        int unsigned      roll;
        roll = $urandom_range(99);
        ack  = $urandom_range(16'hFFFF);
        if (fly_done || fly_next <= fly_base)
        begin
            req = (roll < 60) ? REQ_START : (roll < 90) ? REQ_TICK : REQ_BOGUS;
        end
        else if (roll < 4)
        begin
            req = REQ_START;
        end
        else if (roll < 8)
        begin
            req = REQ_BOGUS;
        end
        else if (roll < 45)
        begin
            req = REQ_TICK;
        end
        else if (roll < 88)
        begin
            req = REQ_ACK;
            if ($urandom_range(1))
                ack = fly_next - 1;
            else
                ack = fly_base + $urandom_range(fly_next - fly_base - 1);
        end
        else
        begin
            // stray ack: one past the sent range, just under the base, or anywhere
            req = REQ_ACK;
            case ($urandom_range(2))
                0: ack = fly_next;
                1: ack = fly_base - 1;
                default: ;
            endcase
        end
        issue(req, ack);
    endtask

    // Drop valid and hold until the checker has every predicted word.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
    endtask

    // Write all three registers once the unit is idle; ends on a rising edge.
    task automatic reprogram(input logic [6:0] window, input logic [31:0] timeout,
                             input logic [15:0] total);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW;
        cfg_data  <= CFG_W'(window);
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge clk);
        cfg_index <= CFG_TOTAL;
        cfg_data  <= CFG_W'(total);
        @(posedge clk);
        cfg_we    <= 1'b0;
        use_window = (window == 0) ? 1 : (window > WINDOW) ? WINDOW : window;
        use_total  = (total == 0) ? 1 : total;
    endtask

    // One random phase: its own register setting and idling mix. hold_at asks for
    // the long receiver hold-off, pause_at lets every result come home first.
    task automatic run_phase(input logic [6:0] window, input logic [31:0] timeout,
                             input logic [15:0] total, input int tx_pct, input int rx_pct,
                             input int words, input int hold_at, input int pause_at);
        int done_n;
        reprogram(window, timeout, total);
        tx_idle_pct   = tx_pct;
        rx_stall_pct <= rx_pct;
        done_n = 0;
        while (done_n < words)
        begin
            if (done_n == hold_at)
            begin
                hold_at    = -1;
                hold_asks <= hold_asks + 1;
            end
            if (done_n == pause_at)
            begin
                pause_at = -1;
                drain();
                @(posedge clk);
            end
            random_request();
            done_n++;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting (window 4, timeout 500, one packet): nothing outstanding,
        // an unknown request, a one-packet transfer, acks out of range and after
        // the end.
        issue(REQ_TICK, 16'd0);
        issue(REQ_ACK, 16'd0);
        issue(REQ_BOGUS, 16'hFFFF);
        issue(REQ_START, 16'd0);
        issue(REQ_ACK, 16'hFFFF);
        issue(REQ_ACK, 16'd0);
        issue(REQ_TICK, 16'd0);
        issue(REQ_ACK, 16'd0);

        // Window far above range acts as the full window; zero timeout makes the
        // first tick resend. Slide, ack under the base, ack at the next unsent
        // packet, then a restart in the middle of the transfer.
        reprogram(7'd127, 32'd0, 16'd40);
        issue(REQ_START, 16'hA5A5);
        issue(REQ_TICK, 16'd0);
        issue(REQ_ACK, 16'd5);
        issue(REQ_ACK, 16'd3);
        issue(REQ_ACK, 16'd22);
        issue(REQ_START, 16'h5A5A);

        // Zero window and zero length act as one; the largest timeout never fires.
        reprogram(7'd0, 32'hFFFF_FFFF, 16'd0);
        issue(REQ_START, 16'd0);
        issue(REQ_TICK, 16'd0);
        issue(REQ_ACK, 16'd0);

        // Longest transfer, timeout 1: the first tick is not late, the second is.
        reprogram(7'd16, 32'd1, 16'hFFFF);
        issue(REQ_START, 16'd0);
        issue(REQ_TICK, 16'd0);
        issue(REQ_TICK, 16'd0);
        issue(REQ_ACK, 16'd15);

        // Random phases: no idling with a long hold-off, sender idle, receiver stalling
        // with a full drain halfway, both idle, no late tick, then random settings.
        run_phase(7'($urandom_range(16, 2)), 32'd2, 16'd40, 0, 0, 70, 10, -1);
        run_phase(7'd17, 32'd5, 16'hFFFF, 60, 0, 70, -1, -1);
        run_phase(7'd3, 32'd1, 16'd20, 0, 60, 70, -1, 30);
        run_phase(7'd1, 32'd0, 16'd9, 12, 12, 70, -1, -1);
        run_phase(7'd127, 32'hFFFF_FFFF, 16'd300, 0, 0, 60, -1, -1);
        run_phase(7'($urandom_range(16, 1)), $urandom_range(6),
                  16'($urandom_range(64, 1)), 12, 12, 80, -1, -1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
